### src/i2crtm_pkg.sv
// Shared types, codes and constants for the I2C register transaction master.
// No dependencies; every other file except i2crtm_if.sv imports this package.
package i2crtm_pkg;

    localparam int DEF_MAX_BYTES = 8;
    localparam logic [7:0] DEV_RD_FLAG = 8'h01;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_XFER_DONE = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RD_DEV  = 4'd1,
        PH_RD_REG  = 4'd2,
        PH_RD_RDEV = 4'd3,
        PH_RD_DATA = 4'd4,
        PH_WR_DEV  = 4'd5,
        PH_WR_REG  = 4'd6,
        PH_WR_DATA = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_SEND   = 3'd2,
        ACT_RSTART = 3'd3,
        ACT_RX_ACK = 3'd4,
        ACT_RX_NAK = 3'd5,
        ACT_STOP   = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_READING    = 3'd1,
        ST_WRITING    = 3'd2,
        ST_READ_DONE  = 3'd3,
        ST_WRITE_DONE = 3'd4,
        ST_REJECTED   = 3'd5
    } t_status;

    typedef struct packed {
        t_phase     phase;
        logic       writing;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [3:0] count;
        logic [3:0] pos;
    } t_seq_state;

    typedef struct packed {
        logic [1:0] op;
        logic       is_write;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [3:0] byte_count;
        logic [7:0] data_byte;
        logic [2:0] byte_index;
    } t_in_item;

    typedef struct packed {
        t_action    bus_action;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [2:0] read_index;
        t_status    status;
    } t_result;

endpackage

### src/i2crtm_if.sv
// Valid/ready channel interfaces for the I2C register transaction master.
// Request/event items go in on i2crtm_in_if, result items come out on i2crtm_out_if.
interface i2crtm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       is_write;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [3:0] byte_count;
    logic [7:0] data_byte;
    logic [2:0] byte_index;

    modport source (
        output valid, op, is_write, device_address, register_address,
        byte_count, data_byte, byte_index,
        input  ready
    );
    modport sink (
        input  valid, op, is_write, device_address, register_address,
        byte_count, data_byte, byte_index,
        output ready
    );
endinterface

interface i2crtm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [2:0] read_index;
    logic [2:0] status;

    modport source (
        output valid, bus_action, bus_byte, read_valid, read_byte,
        read_index, status,
        input  ready
    );
    modport sink (
        input  valid, bus_action, bus_byte, read_valid, read_byte,
        read_index, status,
        output ready
    );
endinterface

### src/i2c_register_transaction_master_core.sv
// I2C register transaction master: top level with state, write buffer and result register.
// Depends on i2crtm_pkg, i2crtm_if.sv and i2crtm_seq.
//
// The result is registered and valid in the cycle after the input transfer. Throughput:
// one item per cycle while the output drains; the whole step is one pass through the
// sequencer between the state registers and the result register, which acts as the skid.
// Reset (synchronous, active low): idle phase, saved fields zero, no result
// pending. The write buffer is not reset; unloaded slots are undefined.
module i2c_register_transaction_master_core #(
    parameter int MAX_BYTES = i2crtm_pkg::DEF_MAX_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2crtm_in_if.sink   i_in,
    i2crtm_out_if.source o_out
);
    import i2crtm_pkg::*;

    // only slots reachable through the 3-bit index need storage
    localparam int BUF_DEPTH = (MAX_BYTES < 8) ? MAX_BYTES : 8;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [6:0] MAX_W   = 7'(MAX_BYTES);
    localparam logic [4:0] DEPTH_W = 5'(BUF_DEPTH);

    t_seq_state r_state;
    t_seq_state n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic [7:0] r_buf [BUF_DEPTH];

    t_in_item   item;
    logic       in_xfer;
    logic [3:0] buf_pos;
    logic [7:0] buf_byte;

    // accept while the result slot is empty or being drained this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign item.op               = i_in.op;
    assign item.is_write         = i_in.is_write;
    assign item.device_address   = i_in.device_address;
    assign item.register_address = i_in.register_address;
    assign item.byte_count       = i_in.byte_count;
    assign item.data_byte        = i_in.data_byte;
    assign item.byte_index       = i_in.byte_index;

    // slots beyond storage read as zero
    assign buf_byte = ({1'b0, buf_pos} < DEPTH_W) ? r_buf[buf_pos[BUF_AW-1:0]] : 8'h00;

    i2crtm_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .i_state    (r_state),
        .i_item     (item),
        .i_buf_byte (buf_byte),
        .o_buf_pos  (buf_pos),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // advance sequencer state and capture the result on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PH_IDLE;
            r_state.writing  <= 1'b0;
            r_state.dev_addr <= 8'h00;
            r_state.reg_addr <= 8'h00;
            r_state.count    <= 4'd0;
            r_state.pos      <= 4'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    // load write data in any phase; drop slots at or beyond the byte limit
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in.op == OP_LOAD) && ({4'b0000, i_in.byte_index} < MAX_W)) begin
            r_buf[i_in.byte_index[BUF_AW-1:0]] <= i_in.data_byte;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.bus_action = r_result.bus_action;
    assign o_out.bus_byte   = r_result.bus_byte;
    assign o_out.read_valid = r_result.read_valid;
    assign o_out.read_byte  = r_result.read_byte;
    assign o_out.read_index = r_result.read_index;
    assign o_out.status     = r_result.status;

endmodule

### src/i2crtm_seq.sv
// Transaction sequencer: next state and result for one item, purely combinational.
// Depends on i2crtm_pkg.
module i2crtm_seq #(
    parameter int MAX_BYTES = i2crtm_pkg::DEF_MAX_BYTES
) (
    input  i2crtm_pkg::t_seq_state i_state,
    input  i2crtm_pkg::t_in_item   i_item,
    input  logic [7:0]             i_buf_byte,
    output logic [3:0]             o_buf_pos,
    output i2crtm_pkg::t_seq_state o_state,
    output i2crtm_pkg::t_result    o_result
);
    import i2crtm_pkg::*;

    localparam logic [6:0] MAX_W = 7'(MAX_BYTES);

    logic       busy;
    logic       req_ok;
    logic [4:0] pos_inc;
    logic [4:0] pos_inc2;
    logic       last;
    t_status    busy_status;

    assign busy     = (i_state.phase != PH_IDLE);
    assign req_ok   = !busy && (i_item.byte_count != 4'd0)
                      && ({3'b000, i_item.byte_count} <= MAX_W);
    assign pos_inc  = {1'b0, i_state.pos} + 5'd1;
    assign pos_inc2 = {1'b0, i_state.pos} + 5'd2;
    assign last     = (pos_inc >= {1'b0, i_state.count});
    assign busy_status = !busy ? ST_IDLE : (i_state.writing ? ST_WRITING : ST_READING);

    // first data slot right after the register address, then the next slot
    assign o_buf_pos = (i_state.phase == PH_WR_REG) ? 4'd0 : pos_inc[3:0];

    // next state
    always_comb begin
        o_state = i_state;
        case (i_item.op)
            OP_REQUEST: begin
                if (req_ok) begin
                    o_state.writing  = i_item.is_write;
                    o_state.dev_addr = i_item.device_address;
                    o_state.reg_addr = i_item.register_address;
                    o_state.count    = i_item.byte_count;
                    o_state.pos      = 4'd0;
                    o_state.phase    = i_item.is_write ? PH_WR_DEV : PH_RD_DEV;
                end
            end
            OP_XFER_DONE: begin
                case (i_state.phase)
                    PH_RD_DEV:  o_state.phase = PH_RD_REG;
                    PH_RD_REG:  o_state.phase = PH_RD_RDEV;
                    PH_RD_RDEV: begin
                        o_state.pos   = 4'd0;
                        o_state.phase = PH_RD_DATA;
                    end
                    PH_RD_DATA, PH_WR_DATA: begin
                        if (last) begin
                            o_state.phase = PH_IDLE;
                        end else begin
                            o_state.pos = pos_inc[3:0];
                        end
                    end
                    PH_WR_DEV:  o_state.phase = PH_WR_REG;
                    PH_WR_REG: begin
                        o_state.pos   = 4'd0;
                        o_state.phase = PH_WR_DATA;
                    end
                    default:    o_state.phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // result
    always_comb begin
        o_result            = '0;
        o_result.bus_action = ACT_NONE;
        o_result.status     = busy_status;
        case (i_item.op)
            OP_REQUEST: begin
                if (req_ok) begin
                    o_result.bus_action = ACT_START;
                    o_result.bus_byte   = i_item.device_address;
                    o_result.status     = i_item.is_write ? ST_WRITING : ST_READING;
                end else begin
                    o_result.status = ST_REJECTED;
                end
            end
            OP_XFER_DONE: begin
                case (i_state.phase)
                    PH_RD_DEV, PH_WR_DEV: begin
                        o_result.bus_action = ACT_SEND;
                        o_result.bus_byte   = i_state.reg_addr;
                    end
                    PH_RD_REG: begin
                        o_result.bus_action = ACT_RSTART;
                        o_result.bus_byte   = i_state.dev_addr | DEV_RD_FLAG;
                    end
                    PH_RD_RDEV: begin
                        o_result.bus_action = (i_state.count == 4'd1) ? ACT_RX_NAK
                                                                       : ACT_RX_ACK;
                    end
                    PH_RD_DATA: begin
                        o_result.read_valid = 1'b1;
                        o_result.read_byte  = i_item.data_byte;
                        o_result.read_index = i_state.pos[2:0];
                        if (last) begin
                            o_result.bus_action = ACT_STOP;
                            o_result.status     = ST_READ_DONE;
                        end else begin
                            o_result.bus_action =
                                (pos_inc2 == {1'b0, i_state.count}) ? ACT_RX_NAK
                                                                    : ACT_RX_ACK;
                        end
                    end
                    PH_WR_REG: begin
                        o_result.bus_action = ACT_SEND;
                        o_result.bus_byte   = i_buf_byte;
                    end
                    PH_WR_DATA: begin
                        if (last) begin
                            o_result.bus_action = ACT_STOP;
                            o_result.status     = ST_WRITE_DONE;
                        end else begin
                            o_result.bus_action = ACT_SEND;
                            o_result.bus_byte   = i_buf_byte;
                        end
                    end
                    default: o_result.status = ST_IDLE;
                endcase
            end
            default: ;
        endcase
    end

endmodule

### dv/i2crtm_checker.sv
// Scoreboard for the I2C register transaction master: predicts each result from accepted items.
// Depends on i2crtm_pkg and the channel interfaces in i2crtm_if.sv.
`timescale 1ns / 1ps

module i2crtm_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    i2crtm_in_if   i_in_mon,
    i2crtm_out_if  i_out_mon,
    output int     o_fail_count,
    output int     o_pending
);
    import i2crtm_pkg::*;

    // Predicted sequencer state
    t_phase     seq_phase;
    logic       seq_writing;
    logic [7:0] seq_dev;
    logic [7:0] seq_reg;
    logic [3:0] seq_count;
    logic [3:0] seq_pos;
    logic [7:0] wbuf [DEF_MAX_BYTES];

    t_result    expected_results [$];
    t_result    exp_res;
    t_in_item   seen_item;
    int         fails = 0;

    function automatic t_status busy_status();
        if (seq_phase == PH_IDLE) begin
            return ST_IDLE;
        end
        return seq_writing ? ST_WRITING : ST_READING;
    endfunction

    function automatic t_action rx_action();
        return (int'(seq_pos) + 1 == int'(seq_count)) ? ACT_RX_NAK : ACT_RX_ACK;
    endfunction

    function automatic t_result next_bus_result(t_in_item it);
        t_result r;
        r.bus_action = ACT_NONE;
        r.bus_byte   = 8'h00;
        r.read_valid = 1'b0;
        r.read_byte  = 8'h00;
        r.read_index = 3'd0;
        r.status     = ST_IDLE;
        case (it.op)
            OP_REQUEST: begin
                if (seq_phase != PH_IDLE || it.byte_count == 4'd0 ||
                    int'(it.byte_count) > DEF_MAX_BYTES) begin
                    r.status = ST_REJECTED;
                end else begin
                    seq_writing  = it.is_write;
                    seq_dev      = it.device_address;
                    seq_reg      = it.register_address;
                    seq_count    = it.byte_count;
                    seq_pos      = 4'd0;
                    seq_phase    = it.is_write ? PH_WR_DEV : PH_RD_DEV;
                    r.bus_action = ACT_START;
                    r.bus_byte   = it.device_address;
                    r.status     = busy_status();
                end
            end
            OP_XFER_DONE: begin
                r.status = busy_status();
                case (seq_phase)
                    PH_RD_DEV: begin
                        r.bus_action = ACT_SEND;
                        r.bus_byte   = seq_reg;
                        seq_phase    = PH_RD_REG;
                    end
                    PH_RD_REG: begin
                        r.bus_action = ACT_RSTART;
                        r.bus_byte   = seq_dev | DEV_RD_FLAG;
                        seq_phase    = PH_RD_RDEV;
                    end
                    PH_RD_RDEV: begin
                        seq_pos      = 4'd0;
                        r.bus_action = rx_action();
                        seq_phase    = PH_RD_DATA;
                    end
                    PH_RD_DATA: begin
                        r.read_valid = 1'b1;
                        r.read_byte  = it.data_byte;
                        r.read_index = seq_pos[2:0];
                        if (int'(seq_pos) + 1 >= int'(seq_count)) begin
                            r.bus_action = ACT_STOP;
                            r.status     = ST_READ_DONE;
                            seq_phase    = PH_IDLE;
                        end else begin
                            seq_pos      = seq_pos + 4'd1;
                            r.bus_action = rx_action();
                        end
                    end
                    PH_WR_DEV: begin
                        r.bus_action = ACT_SEND;
                        r.bus_byte   = seq_reg;
                        seq_phase    = PH_WR_REG;
                    end
                    PH_WR_REG: begin
                        seq_pos      = 4'd0;
                        r.bus_action = ACT_SEND;
                        r.bus_byte   = wbuf[0];
                        seq_phase    = PH_WR_DATA;
                    end
                    PH_WR_DATA: begin
                        if (int'(seq_pos) + 1 >= int'(seq_count)) begin
                            r.bus_action = ACT_STOP;
                            r.status     = ST_WRITE_DONE;
                            seq_phase    = PH_IDLE;
                        end else begin
                            seq_pos      = seq_pos + 4'd1;
                            r.bus_action = ACT_SEND;
                            r.bus_byte   = wbuf[seq_pos[2:0]];
                        end
                    end
                    default: begin
                        seq_phase = PH_IDLE;
                        r.status  = ST_IDLE;
                    end
                endcase
            end
            default: begin
                if (it.op == OP_LOAD) begin
                    wbuf[it.byte_index] = it.data_byte;
                end
                r.status = busy_status();
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int exp_val, logic [7:0] act_val);
        if (act_val !== exp_val[7:0]) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_phase   = PH_IDLE;
            seq_writing = 1'b0;
            seq_dev     = 8'h00;
            seq_reg     = 8'h00;
            seq_count   = 4'd0;
            seq_pos     = 4'd0;
            expected_results.delete();
        end else begin
            // Results first: the item accepted at this edge cannot have its result out yet
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no pending expectation");
                    fails++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("bus_action", int'(exp_res.bus_action), 8'(i_out_mon.bus_action));
                    check_field("bus_byte", int'(exp_res.bus_byte), i_out_mon.bus_byte);
                    check_field("read_valid", int'(exp_res.read_valid), 8'(i_out_mon.read_valid));
                    check_field("read_byte", int'(exp_res.read_byte), i_out_mon.read_byte);
                    check_field("read_index", int'(exp_res.read_index), 8'(i_out_mon.read_index));
                    check_field("status", int'(exp_res.status), 8'(i_out_mon.status));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                seen_item.op               = i_in_mon.op;
                seen_item.is_write         = i_in_mon.is_write;
                seen_item.device_address   = i_in_mon.device_address;
                seen_item.register_address = i_in_mon.register_address;
                seen_item.byte_count       = i_in_mon.byte_count;
                seen_item.data_byte        = i_in_mon.data_byte;
                seen_item.byte_index       = i_in_mon.byte_index;
                expected_results.push_back(next_bus_result(seen_item));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the I2C register transaction master: clock, reset, stimulus and verdict.
// Depends on i2crtm_pkg, i2crtm_if.sv, the core and the i2crtm_checker scoreboard.
`timescale 1ns / 1ps

module tb;
    import i2crtm_pkg::*;

    logic i_clk;
    logic i_rst_n;

    i2crtm_in_if  in_ch ();
    i2crtm_out_if out_ch ();

    int fail_count;
    int pending;

    // Stimulus knobs and bookkeeping
    bit sender_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int items_sent  = 0;
    int n_reads     = 0;
    int n_writes    = 0;
    int n_rejects   = 0;
    int stall_left  = 0;

    i2c_register_transaction_master_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    i2crtm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard ceiling on run length; far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("i2c_register_transaction_master_core: mismatch");
        $finish;
    end

    // Result sink: drop ready in bursts of random length while stalls are enabled
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Fill every field with random content so unused fields toggle too
    function automatic t_in_item random_item(logic [1:0] op);
        t_in_item it;
        it.op               = op;
        it.is_write         = 1'($urandom_range(0, 1));
        it.device_address   = 8'($urandom_range(0, 255));
        it.register_address = 8'($urandom_range(0, 255));
        it.byte_count       = 4'($urandom_range(0, 15));
        it.data_byte        = 8'($urandom_range(0, 255));
        it.byte_index       = 3'($urandom_range(0, 7));
        return it;
    endfunction

    // Present one item and hold it until the transfer; valid stays high for the next item
    task automatic push(t_in_item it, bit counts);
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.op               <= it.op;
        in_ch.is_write         <= it.is_write;
        in_ch.device_address   <= it.device_address;
        in_ch.register_address <= it.register_address;
        in_ch.byte_count       <= it.byte_count;
        in_ch.data_byte        <= it.data_byte;
        in_ch.byte_index       <= it.byte_index;
        do @(posedge i_clk); while (!in_ch.ready);
        if (counts) begin
            items_sent++;
        end
    endtask

    task automatic do_request(bit wr, logic [7:0] dev, logic [7:0] regad, logic [3:0] cnt);
        t_in_item it;
        it                  = random_item(OP_REQUEST);
        it.is_write         = wr;
        it.device_address   = dev;
        it.register_address = regad;
        it.byte_count       = cnt;
        push(it, 1'b1);
    endtask

    task automatic do_xfer(logic [7:0] data, bit counts);
        t_in_item it;
        it           = random_item(OP_XFER_DONE);
        it.data_byte = data;
        push(it, counts);
    endtask

    task automatic do_load(logic [2:0] slot, logic [7:0] data);
        t_in_item it;
        it            = random_item(OP_LOAD);
        it.byte_index = slot;
        it.data_byte  = data;
        push(it, 1'b1);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Noise while a transaction is open: loads, nops and requests that must be rejected
    task automatic busy_noise();
        case ($urandom_range(0, 2))
            0: do_load(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            1: push(random_item(OP_NOP), 1'b0);
            default: begin
                push(random_item(OP_REQUEST), 1'b1);
                n_rejects++;
            end
        endcase
    endtask

    // Noise while idle: stray transfer-done, nops, loads and bad-count requests
    task automatic idle_noise();
        case ($urandom_range(0, 3))
            0: do_xfer(8'($urandom_range(0, 255)), 1'b0);
            1: push(random_item(OP_NOP), 1'b0);
            2: do_load(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            default: begin
                do_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)),
                           ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15)));
                n_rejects++;
            end
        endcase
    endtask

    // One well-formed transaction with random content, optionally broken up by noise
    task automatic run_transaction();
        bit wr;
        int cnt;
        int n_xfer;
        bit broken;
        wr     = 1'($urandom_range(0, 1));
        cnt    = $urandom_range(1, DEF_MAX_BYTES);
        broken = ($urandom_range(0, 9) == 0);
        n_xfer = wr ? cnt + 2 : cnt + 3;
        if (wr) begin
            repeat ($urandom_range(0, 4)) begin
                do_load(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end
        do_request(wr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 4'(cnt));
        for (int i = 0; i < n_xfer; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                busy_noise();
            end
            if (broken && i == n_xfer / 2) begin
                repeat ($urandom_range(3, 6)) busy_noise();
            end
            do_xfer(8'($urandom_range(0, 255)), 1'b1);
        end
        if (wr) begin
            n_writes++;
        end else begin
            n_reads++;
        end
    endtask

    initial begin
        int next_drain;
        // Known values on every input from time zero
        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.op               <= OP_NOP;
        in_ch.is_write         <= 1'b0;
        in_ch.device_address   <= 8'h00;
        in_ch.register_address <= 8'h00;
        in_ch.byte_count       <= 4'd0;
        in_ch.data_byte        <= 8'h00;
        in_ch.byte_index       <= 3'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill every buffer slot first so no write ever sends an unloaded slot
        for (int s = 0; s < DEF_MAX_BYTES; s++) begin
            do_load(3'(s), (s == 0) ? 8'h00 : (s == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
        end
        // Single-byte read with the all-ones device address; a request mid-read is rejected
        do_request(1'b0, 8'hFF, 8'h00, 4'd1);
        do_xfer(8'h00, 1'b1);
        do_request(1'b1, 8'h12, 8'h34, 4'd2);
        n_rejects++;
        do_xfer(8'h00, 1'b1);
        do_xfer(8'h00, 1'b1);
        do_xfer(8'hFF, 1'b1);
        n_reads++;
        // Two-byte write; reload slot one after the register address goes out, before it is sent
        do_request(1'b1, 8'h00, 8'hFF, 4'd2);
        do_xfer(8'h00, 1'b1);
        do_load(3'd1, 8'h3C);
        do_xfer(8'h00, 1'b1);
        do_xfer(8'h00, 1'b1);
        do_xfer(8'h00, 1'b1);
        n_writes++;
        // Zero and over-range counts are rejected, stray transfer-done and nop are ignored
        do_request(1'b0, 8'h50, 8'h0A, 4'd0);
        do_request(1'b1, 8'h50, 8'h0A, 4'd15);
        n_rejects += 2;
        do_xfer(8'hA5, 1'b0);
        push(random_item(OP_NOP), 1'b0);
        drain();

        // Random: mostly complete transactions, some idle noise
        next_drain = 200;
        while (items_sent < 1050) begin
            if (items_sent > 900) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            if ($urandom_range(0, 9) < 8) begin
                run_transaction();
            end else begin
                repeat ($urandom_range(1, 3)) idle_noise();
            end
            if (items_sent >= next_drain) begin
                drain();
                next_drain += 200;
            end
        end

        // Let everything outstanding come back, then a few idle cycles
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("covered %0d reads and %0d writes of 1 to %0d bytes, %0d rejected requests,",
                 n_reads, n_writes, DEF_MAX_BYTES, n_rejects);
        $display("stray events, nops and loads mid-transaction over %0d counted items",
                 items_sent);
        if (fail_count == 0 && pending == 0) begin
            $display("i2c_register_transaction_master_core: match");
        end else begin
            $display("i2c_register_transaction_master_core: mismatch");
        end
        $finish;
    end

endmodule
